>>> rtl/sensor_response_frame_checker_defines.svh
// ----------------------------------------------------------------------------
// Sensor response frame checker - assertion macros
// Shared property wrappers, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SENSOR_RESPONSE_FRAME_CHECKER_DEFINES_SVH
`define SENSOR_RESPONSE_FRAME_CHECKER_DEFINES_SVH

// same-cycle implication
`define SRFC_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SRFC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/srfc_pkg.sv
// ----------------------------------------------------------------------------
// srfc_pkg
// Types, constants and the CRC16 byte update for the response frame checker.
// ----------------------------------------------------------------------------
package srfc_pkg;

   localparam int MAX_PAYLOAD_DEFAULT = 7;
   localparam int PAYLOAD_VIEW        = 7;   // longest payload that is decoded

   localparam logic [7:0]  FUNC_CODE     = 8'h03;
   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam logic [15:0] CRC_POLY      = 16'hA001;
   localparam logic [15:0] DEFAULT_MODEL = 16'd2320;
   localparam logic [3:0]  PLEN_MEASURE  = 4'd4;
   localparam logic [3:0]  PLEN_INFO     = 4'd7;
   localparam logic [3:0]  INDEX_LIMIT   = PLEN_INFO + 4'd4;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_HEADER = 2'd1,
      STATUS_CRC    = 2'd2
   } status_type;

   typedef enum logic {
      KIND_MEASURE = 1'b0,
      KIND_INFO    = 1'b1
   } frame_kind_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [15:0]        humidity_tenths;
      logic signed [15:0] temperature_tenths;
      logic [15:0]        model_number;
      logic [7:0]         version_number;
      logic [31:0]        device_serial;
   } rsp_type;

   // frame tracker -> decoder
   typedef struct packed {
      logic                         emit;
      logic                         header_good;
      logic                         crc_match;
      logic [PAYLOAD_VIEW-1:0][7:0] payload;
   } frame_evt_type;

   // reflected CRC16, one byte, eight shift steps
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

>>> rtl/srfc_frame_track.sv
// ----------------------------------------------------------------------------
// srfc_frame_track
// Byte position, running CRC, header check and payload capture.
// ----------------------------------------------------------------------------
`include "sensor_response_frame_checker_defines.svh"

module srfc_frame_track #(
   parameter int MAX_PAYLOAD = srfc_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  srfc_pkg::req_type        req_data,
   input  srfc_pkg::frame_kind_type frame_kind,
   output srfc_pkg::frame_evt_type  frame_evt
);

   logic [3:0]  byte_index_ff, byte_index_in;
   logic [15:0] crc_ff, crc_in;
   logic        header_good_ff, header_good_in;
   logic [7:0]  crc_low_ff, crc_low_in;
   logic [7:0]  payload_ff [MAX_PAYLOAD];

   logic [3:0]  plen, last, last_plus_one, idx_eff;
   logic [15:0] crc_eff;
   logic        header_eff, active, body;

   always_comb begin
      plen          = (frame_kind == srfc_pkg::KIND_INFO) ? srfc_pkg::PLEN_INFO
                                                          : srfc_pkg::PLEN_MEASURE;
      last          = plen + 4'd3;
      last_plus_one = plen + 4'd4;
      idx_eff       = req_data.frame_start ? 4'd0 : byte_index_ff;
      crc_eff       = req_data.frame_start ? srfc_pkg::CRC_INIT : crc_ff;
      header_eff    = req_data.frame_start ? 1'b1 : header_good_ff;
      active        = (idx_eff <= last);
      body          = (idx_eff < (plen + 4'd2));
   end

   always_comb begin
      byte_index_in  = byte_index_ff;
      crc_in         = crc_ff;
      header_good_in = header_good_ff;
      crc_low_in     = crc_low_ff;
      if (accept) begin
         byte_index_in  = idx_eff;
         crc_in         = crc_eff;
         header_good_in = header_eff;
         if (active) begin
            byte_index_in = idx_eff + 4'd1;
            if (body) begin
               if ((idx_eff == 4'd0) && (req_data.rx_byte != srfc_pkg::FUNC_CODE)) begin
                  header_good_in = 1'b0;
               end
               if ((idx_eff == 4'd1) && (req_data.rx_byte != {4'd0, plen})) begin
                  header_good_in = 1'b0;
               end
               crc_in = srfc_pkg::crc_feed(crc_eff, req_data.rx_byte);
            end else if (idx_eff == (plen + 4'd2)) begin
               crc_low_in = req_data.rx_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff  <= 4'd0;
         crc_ff         <= srfc_pkg::CRC_INIT;
         header_good_ff <= 1'b1;
         crc_low_ff     <= 8'h00;
      end else begin
         byte_index_ff  <= byte_index_in;
         crc_ff         <= crc_in;
         header_good_ff <= header_good_in;
         crc_low_ff     <= crc_low_in;
      end
   end

   // payload capture, one entry per position
   for (genvar i = 0; i < MAX_PAYLOAD; i++) begin : g_store
      always_ff @(posedge clock) begin
         if (accept && active && body && (idx_eff == 4'(i + 2))) begin
            payload_ff[i] <= req_data.rx_byte;
         end
      end
   end

   // decoded view; positions past the store read as zero
   for (genvar i = 0; i < srfc_pkg::PAYLOAD_VIEW; i++) begin : g_view
      if (i < MAX_PAYLOAD) begin : g_held
         assign frame_evt.payload[i] = payload_ff[i];
      end else begin : g_none
         assign frame_evt.payload[i] = 8'h00;
      end
   end

   // CRC state is only ever used on the last byte, never right after a restart
   assign frame_evt.emit        = accept && active && (idx_eff == last);
   assign frame_evt.header_good = header_good_ff;
   assign frame_evt.crc_match   = ({req_data.rx_byte, crc_low_ff} == crc_ff);

   `SRFC_ASSERT_NEXT(a_emit_parks_index, frame_evt.emit, byte_index_ff == $past(last_plus_one), "index not parked after frame end")
   `SRFC_ASSERT_IMPLY(a_index_bound, 1'b1, byte_index_ff <= srfc_pkg::INDEX_LIMIT, "byte index out of range")

endmodule

>>> rtl/srfc_decode.sv
// ----------------------------------------------------------------------------
// srfc_decode
// Frame status and field decode for measurement and info responses.
// ----------------------------------------------------------------------------
module srfc_decode (
   input  srfc_pkg::frame_evt_type  frame_evt,
   input  srfc_pkg::frame_kind_type frame_kind,
   output srfc_pkg::rsp_type        rsp_out
);

   logic [14:0] temp_mag;
   logic [15:0] temp_wide;
   logic [15:0] model_raw;

   always_comb begin
      temp_mag  = {frame_evt.payload[2][6:0], frame_evt.payload[3]};
      temp_wide = {1'b0, temp_mag};
      model_raw = {frame_evt.payload[0], frame_evt.payload[1]};

      rsp_out = '0;
      if (!frame_evt.header_good) begin
         rsp_out.status = srfc_pkg::STATUS_HEADER;
      end else if (!frame_evt.crc_match) begin
         rsp_out.status = srfc_pkg::STATUS_CRC;
      end else begin
         rsp_out.status = srfc_pkg::STATUS_OK;
         if (frame_kind == srfc_pkg::KIND_MEASURE) begin
            rsp_out.humidity_tenths = {frame_evt.payload[0], frame_evt.payload[1]};
            // sign-magnitude; negative zero folds to zero
            rsp_out.temperature_tenths = frame_evt.payload[2][7] ? $signed(16'(-temp_wide))
                                                                 : $signed(temp_wide);
         end else begin
            rsp_out.model_number   = (model_raw == 16'd0) ? srfc_pkg::DEFAULT_MODEL
                                                          : model_raw;
            rsp_out.version_number = frame_evt.payload[2];
            rsp_out.device_serial  = {frame_evt.payload[3], frame_evt.payload[4],
                                      frame_evt.payload[5], frame_evt.payload[6]};
         end
      end
   end

endmodule

>>> rtl/srfc_rsp_buffer.sv
// ----------------------------------------------------------------------------
// srfc_rsp_buffer
// Result register with one skid entry behind it.
// ----------------------------------------------------------------------------
`include "sensor_response_frame_checker_defines.svh"

module srfc_rsp_buffer (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  srfc_pkg::rsp_type push_data,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output srfc_pkg::rsp_type rsp_data,
   output logic              full
);

   logic              main_valid_ff, main_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   srfc_pkg::rsp_type main_data_ff, main_data_in;
   srfc_pkg::rsp_type skid_data_ff, skid_data_in;
   logic              take;

   always_comb begin
      take          = main_valid_ff && !rsp_stall;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || take) begin
            main_valid_in = 1'b1;
            main_data_in  = push_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = push_data;
         end
      end else if (take) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_data_ff;
   assign full      = skid_valid_ff;

   `SRFC_ASSERT_IMPLY(a_skid_behind_main, skid_valid_ff, main_valid_ff, "skid entry without result entry")
   `SRFC_ASSERT_IMPLY(a_no_push_when_full, push, !skid_valid_ff, "result pushed into full buffer")
   `SRFC_ASSERT_NEXT(a_push_shows, push, main_valid_ff, "pushed result not presented")

endmodule

>>> rtl/sensor_response_frame_checker.sv
// ----------------------------------------------------------------------------
// sensor_response_frame_checker
// Byte-wise checker and decoder for humidity/temperature sensor read responses.
// ----------------------------------------------------------------------------
// Feed the response one byte per transfer on req_: function code 0x03, length
// byte, payload (4 bytes in measurement mode, 7 in info mode, chosen by the
// one-bit csr register), CRC low, CRC high. The CRC16 (reflected 0xA001, init
// 0xFFFF) covers header and payload and is updated for each byte in the cycle
// the byte is taken, so the block takes one byte every cycle while req_stall is
// low. On the last byte of a frame a result with status (ok, bad header, CRC
// mismatch; header wins) and the decoded fields of the selected mode goes to
// the result register, on rsp_ in the next cycle if it is free or taken, else
// to the skid entry behind it. Fields of the other mode, and all fields of a
// failed frame, are zero. Setting frame_start on a byte restarts the frame
// there and drops a partial one without a result; bytes after a complete frame
// are ignored until the next frame_start. Right after reset the block already
// waits for the first byte of a frame. req_stall rises only while two results
// wait on a stalled rsp_ side, which cannot happen while results are drained
// at the rate frames arrive. Change the csr register only between frames.
// ----------------------------------------------------------------------------
module sensor_response_frame_checker #(
   parameter int MAX_PAYLOAD = srfc_pkg::MAX_PAYLOAD_DEFAULT   // stored payload bytes, 4..8
) (
   input  logic              clock,
   input  logic              reset,

   // byte input
   input  logic              req_valid,
   output logic              req_stall,
   input  srfc_pkg::req_type req_data,

   // result output
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output srfc_pkg::rsp_type rsp_data,

   // frame kind register
   input  logic              csr_write_enable,
   input  logic              csr_write_data
);

   srfc_pkg::frame_kind_type frame_kind_ff, frame_kind_in;
   srfc_pkg::frame_evt_type  frame_evt;
   srfc_pkg::rsp_type        decoded;
   logic                     accept;
   logic                     buffer_full;

   // frame kind register; user must write it only between frames, block does not enforce it
   always_comb begin
      frame_kind_in = frame_kind_ff;
      if (csr_write_enable) begin
         frame_kind_in = srfc_pkg::frame_kind_type'(csr_write_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_kind_ff <= srfc_pkg::KIND_MEASURE;
      end else begin
         frame_kind_ff <= frame_kind_in;
      end
   end

   // a byte transfer completes whenever the skid entry is free
   assign req_stall = buffer_full;
   assign accept    = req_valid && !req_stall;

   // position, CRC, header check and payload store
   srfc_frame_track #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_track (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_data   (req_data),
      .frame_kind (frame_kind_ff),
      .frame_evt  (frame_evt)
   );

   // status and field decode on the last byte
   srfc_decode u_decode (
      .frame_evt  (frame_evt),
      .frame_kind (frame_kind_ff),
      .rsp_out    (decoded)
   );

   // result register plus skid entry
   srfc_rsp_buffer u_buffer (
      .clock     (clock),
      .reset     (reset),
      .push      (frame_evt.emit),
      .push_data (decoded),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .full      (buffer_full)
   );

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench - sensor response frame checker
// Self-checking bench. Sends response frames byte by byte, in measurement and
// info mode, and keeps a cycle-level model of the frame tracker and CRC16.
// Every result transfer is checked field by field against the model's next
// expected reading. Random gaps on both sides, a long result backlog, noise
// bytes, broken frames and restarted frames are included.
// ----------------------------------------------------------------------------
module testbench;

   // Fault injected into a generated frame
   typedef enum {
      FRAME_GOOD,
      FRAME_BAD_FUNC,
      FRAME_BAD_LEN,
      FRAME_BAD_CRC,
      FRAME_BAD_BOTH,
      FRAME_CUT
   } frame_fault_type;

   typedef logic [7:0] byte_queue_type[$];

   // ---------------------------------------------------------------- DUT I/O
   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   srfc_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   srfc_pkg::rsp_type rsp_data;
   logic              csr_write_enable = 1'b0;
   logic              csr_write_data = 1'b0;

   sensor_response_frame_checker u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------- shared controls
   bit                       idle_on = 1'b1;     // random gaps on both channels
   int                       hold_pending = 0;   // one-shot long stall for the receiver
   srfc_pkg::frame_kind_type cfg_kind = srfc_pkg::KIND_MEASURE;   // what the stimulus was told
   int                       mismatch_count = 0;

   // ------------------------------------------------------- frame predictor
   // Mirror of the block's tracker: position in frame, running CRC, header
   // flag, stored payload and the CRC low byte.
   int                       rx_pos;
   logic [15:0]              crc_acc;
   bit                       header_ok;
   logic [7:0]               payload_copy [0:6];
   logic [7:0]               crc_low_seen;
   srfc_pkg::frame_kind_type kind_now;
   srfc_pkg::rsp_type        expected_readings[$];

   // Reflected CRC16, fed one bit at a time, LSB first
   function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] d);
      logic fb;
      for (int i = 0; i < 8; i++) begin
         fb = c[0] ^ d[i];
         c = c >> 1;
         if (fb) c = c ^ srfc_pkg::CRC_POLY;
      end
      return c;
   endfunction

   function automatic void restart_frame();
      rx_pos = 0;
      crc_acc = srfc_pkg::CRC_INIT;
      header_ok = 1'b1;
   endfunction

   // One accepted byte; queues a reading when the byte closes a frame
   function automatic void track_rx_byte(input srfc_pkg::req_type r);
      int                plen;
      logic [15:0]       got_crc;
      logic [15:0]       mag;
      srfc_pkg::rsp_type want;
      plen = (kind_now == srfc_pkg::KIND_INFO) ? int'(srfc_pkg::PLEN_INFO)
                                               : int'(srfc_pkg::PLEN_MEASURE);
      if (r.frame_start) restart_frame();
      // past the end of a complete frame: byte is dropped
      if (rx_pos > plen + 3) return;
      rx_pos++;
      if (rx_pos - 1 < plen + 2) begin
         if (rx_pos == 1 && r.rx_byte != srfc_pkg::FUNC_CODE) header_ok = 1'b0;
         if (rx_pos == 2 && r.rx_byte != 8'(plen)) header_ok = 1'b0;
         if (rx_pos >= 3) payload_copy[rx_pos - 3] = r.rx_byte;
         crc_acc = crc_step(crc_acc, r.rx_byte);
      end else if (rx_pos - 1 == plen + 2) begin
         crc_low_seen = r.rx_byte;
      end else begin
         want = '0;
         got_crc = {r.rx_byte, crc_low_seen};
         if (!header_ok) want.status = srfc_pkg::STATUS_HEADER;
         else if (got_crc != crc_acc) want.status = srfc_pkg::STATUS_CRC;
         else want.status = srfc_pkg::STATUS_OK;
         // failed frames and the other mode's fields stay zero
         if (want.status == srfc_pkg::STATUS_OK) begin
            if (kind_now == srfc_pkg::KIND_MEASURE) begin
               want.humidity_tenths = {payload_copy[0], payload_copy[1]};
               mag = {1'b0, payload_copy[2][6:0], payload_copy[3]};
               // sign-magnitude; negative zero comes out as 0
               want.temperature_tenths = payload_copy[2][7] ? 16'd0 - mag : mag;
            end else begin
               want.model_number = {payload_copy[0], payload_copy[1]};
               if (want.model_number == 16'd0) want.model_number = srfc_pkg::DEFAULT_MODEL;
               want.version_number = payload_copy[2];
               want.device_serial = {payload_copy[3], payload_copy[4],
                                     payload_copy[5], payload_copy[6]};
            end
         end
         expected_readings.push_back(want);
      end
   endfunction

   // ------------------------------------------------------- result checking
   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic void check_reading(input srfc_pkg::rsp_type got);
      srfc_pkg::rsp_type want;
      if (expected_readings.size() == 0) begin
         $display("%0t: result with nothing expected, expected none, got %h", $time, got);
         mismatch_count++;
         return;
      end
      want = expected_readings.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("humidity_tenths", want.humidity_tenths, got.humidity_tenths);
      compare_field("temperature_tenths", want.temperature_tenths,
                    got.temperature_tenths);
      compare_field("model_number", want.model_number, got.model_number);
      compare_field("version_number", want.version_number, got.version_number);
      compare_field("device_serial", want.device_serial, got.device_serial);
   endfunction

   // Sample at the edge: inputs and outputs are read before any update lands
   always @(posedge clock) begin
      if (reset) begin
         restart_frame();
         for (int i = 0; i < 7; i++) payload_copy[i] = 8'h00;
         crc_low_seen = 8'h00;
         kind_now = srfc_pkg::KIND_MEASURE;
      end else begin
         if (csr_write_enable) kind_now = srfc_pkg::frame_kind_type'(csr_write_data);
         if (req_valid && !req_stall) track_rx_byte(req_data);
         if (rsp_valid && !rsp_stall) check_reading(rsp_data);
      end
   end

   // ------------------------------------------------------- result receiver
   // Stalls a random number of cycles before each transfer; a pending hold
   // is added once to build up a backlog inside the block.
   initial begin : result_receiver
      int wait_cycles;
      forever begin
         wait_cycles = idle_on ? $urandom_range(0, 6) : 0;
         wait_cycles += hold_pending;
         hold_pending = 0;
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // ------------------------------------------------------- stimulus helpers
   // One byte transfer; valid stays high afterwards so back-to-back bytes
   // need no dead cycle.
   task automatic send_byte(input logic [7:0] value, input bit start);
      int                gap;
      srfc_pkg::req_type item;
      gap = idle_on ? $urandom_range(0, 6) : 0;
      item.rx_byte = value;
      item.frame_start = start;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
   endtask

   // Lets the block drain, then a few cycles more for bytes with no result.
   // The current edge passes first, so its byte is already logged.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_frame_kind(input srfc_pkg::frame_kind_type kind);
      wait_for_results();
      csr_write_enable <= 1'b1;
      csr_write_data <= kind;
      cfg_kind = kind;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [7:0] random_octet();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h80;
         3: return 8'h7F;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] other_byte(input logic [7:0] avoid);
      logic [7:0] b;
      do b = 8'($urandom); while (b == avoid);
      return b;
   endfunction

   function automatic byte_queue_type random_body();
      byte_queue_type body;
      int             n;
      n = (cfg_kind == srfc_pkg::KIND_INFO) ? int'(srfc_pkg::PLEN_INFO)
                                            : int'(srfc_pkg::PLEN_MEASURE);
      repeat (n) body.push_back(random_octet());
      return body;
   endfunction

   // Wraps a payload in header and CRC, applies the fault, sends the bytes
   task automatic send_frame(input byte_queue_type body, input frame_fault_type fault,
                             input bit mark_start);
      byte_queue_type frame_bytes;
      logic [15:0]    crc;
      logic [7:0]     len_byte;
      int             keep;
      len_byte = (cfg_kind == srfc_pkg::KIND_INFO) ? 8'(srfc_pkg::PLEN_INFO)
                                                   : 8'(srfc_pkg::PLEN_MEASURE);
      frame_bytes.push_back(srfc_pkg::FUNC_CODE);
      if (fault == FRAME_BAD_FUNC || fault == FRAME_BAD_BOTH)
         frame_bytes[0] = other_byte(srfc_pkg::FUNC_CODE);
      if (fault == FRAME_BAD_LEN) begin
         // half the time the other mode's length, a likely real-world slip
         if ($urandom_range(0, 1))
            len_byte = (cfg_kind == srfc_pkg::KIND_INFO) ? 8'(srfc_pkg::PLEN_MEASURE)
                                                         : 8'(srfc_pkg::PLEN_INFO);
         else
            len_byte = other_byte(len_byte);
      end
      frame_bytes.push_back(len_byte);
      foreach (body[i]) frame_bytes.push_back(body[i]);
      crc = srfc_pkg::CRC_INIT;
      foreach (frame_bytes[i]) crc = crc_step(crc, frame_bytes[i]);
      if (fault == FRAME_BAD_CRC || fault == FRAME_BAD_BOTH)
         crc = crc ^ (16'd1 << $urandom_range(0, 15));
      frame_bytes.push_back(crc[7:0]);
      frame_bytes.push_back(crc[15:8]);
      keep = frame_bytes.size();
      if (fault == FRAME_CUT) keep = $urandom_range(1, keep - 1);
      for (int i = 0; i < keep; i++) send_byte(frame_bytes[i], mark_start && i == 0);
   endtask

   // Mostly clean frames with random content, plus broken frames and noise.
   // Noise bytes are not counted toward the target.
   task automatic run_random_frames(input int target_bytes);
      int              sent;
      int              pick;
      bit              first;
      byte_queue_type  body;
      frame_fault_type fault;
      sent = 0;
      first = 1'b1;
      while (sent < target_bytes) begin
         body = random_body();
         // first frame of a run is clean and marked, so no stale partial
         // frame from before a mode change is ever continued
         pick = first ? 0 : $urandom_range(0, 99);
         first = 1'b0;
         if (pick >= 95) begin
            if ($urandom_range(0, 1))
               repeat ($urandom_range(1, 4)) send_byte(random_octet(), 1'b0);
            else
               send_frame(body, FRAME_GOOD, 1'b0);
         end else begin
            if (pick < 70) fault = FRAME_GOOD;
            else if (pick < 78) fault = FRAME_BAD_CRC;
            else if (pick < 83) fault = FRAME_BAD_FUNC;
            else if (pick < 88) fault = FRAME_BAD_LEN;
            else if (pick < 90) fault = FRAME_BAD_BOTH;
            else fault = FRAME_CUT;
            send_frame(body, fault, 1'b1);
            sent += body.size() + 4;
         end
      end
   endtask

   // ------------------------------------------------------- tests
   // Right after reset the block waits for byte 0, so no frame_start needed.
   // Full-scale humidity and the most negative temperature; then two bytes
   // after the complete frame, which must be ignored.
   task automatic test_frame_without_start();
      byte_queue_type body;
      body = {8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_frame(body, FRAME_GOOD, 1'b0);
      send_byte(srfc_pkg::FUNC_CODE, 1'b0);
      send_byte(8'h04, 1'b0);
   endtask

   // Partial frame dropped by a new frame_start; negative zero temperature
   // with zero humidity; a frame bad in both header and CRC (header wins).
   task automatic test_measure_corners();
      byte_queue_type body;
      send_byte(srfc_pkg::FUNC_CODE, 1'b1);
      send_byte(8'h04, 1'b0);
      send_byte(8'h12, 1'b0);
      body = {8'h00, 8'h00, 8'h80, 8'h00};
      send_frame(body, FRAME_GOOD, 1'b1);
      send_frame(random_body(), FRAME_BAD_BOTH, 1'b1);
   endtask

   // Model 0 reads back as the default model; all-ones and all-zeros fields
   task automatic test_info_corners();
      byte_queue_type body;
      set_frame_kind(srfc_pkg::KIND_INFO);
      body = {8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_frame(body, FRAME_GOOD, 1'b1);
      body = {8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      send_frame(body, FRAME_GOOD, 1'b1);
   endtask

   task automatic test_random_info();
      run_random_frames(200);
   endtask

   // Sender pauses mid-test until every result is in
   task automatic test_random_measure();
      set_frame_kind(srfc_pkg::KIND_MEASURE);
      run_random_frames(125);
      wait_for_results();
      run_random_frames(125);
   endtask

   // No gaps on either side: one byte every cycle
   task automatic test_full_rate();
      set_frame_kind(srfc_pkg::KIND_INFO);
      idle_on = 1'b0;
      run_random_frames(150);
      wait_for_results();
      idle_on = 1'b1;
   endtask

   // Receiver holds off long enough that results back up and req_stall rises
   task automatic test_result_backlog();
      set_frame_kind(srfc_pkg::KIND_MEASURE);
      idle_on = 1'b0;
      hold_pending = 160;
      run_random_frames(100);
      idle_on = 1'b1;
      wait_for_results();
   endtask

   // ------------------------------------------------------- sequence
   initial begin : main_sequence
      int waited;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_frame_without_start();
      test_measure_corners();
      test_info_corners();
      test_random_info();
      test_random_measure();
      test_full_rate();
      test_result_backlog();

      // drain, bounded, then a few more cycles to catch stray results
      req_valid <= 1'b0;
      waited = 0;
      while (expected_readings.size() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (expected_readings.size() != 0) begin
         $display("%0t: %0d results never arrived, expected %h, got none", $time,
                  expected_readings.size(), expected_readings[0]);
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run
   initial begin : watchdog
      #(8 * 400000);
      $display("%0t: timeout", $time);
      $display("testbench NOT OK");
      $finish;
   end

endmodule
